/* rtl/assert_macros.svh */
// Assertion macros shared by the version validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VSV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsv assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsv assertion failed");

`endif

/* rtl/vsv_pkg.sv */
// Shared types and constants of the version validator.
package vsv_pkg;

    localparam int DEF_MAX_TEXT_LENGTH = 32;
    localparam int DEF_MAX_PART_DIGITS = 10;

    localparam int BYTE_W  = 8;
    localparam int PART_W  = 32;
    localparam int DIGIT_W = 4;
    localparam int PROD_W  = PART_W + DIGIT_W;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;

    localparam logic [1:0] FIRST_PART = 2'd0;
    localparam logic [1:0] LAST_PART  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } vsv_item_t;

endpackage

/* rtl/version_string_validator_top.sv */
// Top level of the version string validator.
//
// Checks a text of the form major.minor.patch, one byte per input word.
// Input channel: text_valid / text_ready with text_byte and end_of_text;
// end_of_text marks the last byte of a text. Output channel:
// result_valid / result_ready with version_ok, one word per text, sent
// only for the last byte.
// Each byte is registered on entry and scanned from the input register;
// the verdict for a last byte is written to the result register when
// the scanner takes that byte. Throughput is one byte per cycle while
// no last byte waits for the result register, set by the single scan
// step with its times-ten update of the part value.
// Reset clears the scan state and empties both registers; the block then
// takes bytes at once.
// While a result waits untaken, bytes that are not the last of their text
// keep flowing; a last byte waits in the input register until the result
// register is free, and text_ready falls only then.
module version_string_validator_top
    import vsv_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH,
    parameter int MAX_PART_DIGITS = DEF_MAX_PART_DIGITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              version_ok
);

    logic      item_valid;
    vsv_item_t item;
    logic      take;
    logic      push;
    logic      room;
    logic      ok;

    assign take = item_valid && (!item.end_of_text || room);
    assign push = take && item.end_of_text;

    vsv_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    vsv_scan #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH),
        .MAX_PART_DIGITS (MAX_PART_DIGITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .ok    (ok)
    );

    vsv_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .ok           (ok),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .version_ok   (version_ok)
    );

endmodule

/* rtl/vsv_in_reg.sv */
// Input register: holds one accepted word until the scanner takes it.
`include "assert_macros.svh"

module vsv_in_reg
    import vsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    input  logic              take,
    output logic              item_valid,
    output vsv_item_t         item
);

    logic      valid_reg;
    logic      valid_next;
    vsv_item_t item_reg;
    logic      load;

    assign text_ready = !valid_reg || take;
    assign load       = text_valid && text_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.text_byte   <= text_byte;
            item_reg.end_of_text <= end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    `VSV_ASSERT_NOW(a_take_needs_word, take, valid_reg)
    `VSV_ASSERT_NEXT(a_hold_untaken, valid_reg && !take, valid_reg && $stable(item_reg))

endmodule

/* rtl/vsv_scan.sv */
// Scanner: per-byte syntax state and the verdict on the final byte.
`include "assert_macros.svh"

module vsv_scan
    import vsv_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH,
    parameter int MAX_PART_DIGITS = DEF_MAX_PART_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  vsv_item_t item,
    output logic      ok
);

    localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int DIG_W = $clog2(MAX_PART_DIGITS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TEXT_LENGTH);
    localparam logic [DIG_W-1:0] DIG_MAX = DIG_W'(MAX_PART_DIGITS);
    localparam logic [DIG_W-1:0] DIG_ONE = DIG_W'(1);

    logic [1:0]        part_reg,   part_next;
    logic [DIG_W-1:0]  digits_reg, digits_next;
    logic [PART_W-1:0] value_reg,  value_next;
    logic              zero_reg,   zero_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic              failed_reg, failed_next;

    logic               is_digit;
    logic               is_dot;
    logic [DIGIT_W-1:0] digit_val;
    logic [PROD_W-1:0]  wide;
    logic [PROD_W-1:0]  prod;
    logic               len_hit;
    logic               fail;

    assign is_digit  = (item.text_byte >= CHAR_ZERO) && (item.text_byte <= CHAR_NINE);
    assign is_dot    = (item.text_byte == CHAR_DOT);
    assign digit_val = item.text_byte[DIGIT_W-1:0];
    assign wide      = {{DIGIT_W{1'b0}}, value_reg};
    assign prod      = (wide << 3) + (wide << 1) + PROD_W'(digit_val);
    assign len_hit   = (len_reg >= LEN_MAX);

    always_comb
    begin
        part_next   = part_reg;
        digits_next = digits_reg;
        value_next  = value_reg;
        zero_next   = zero_reg;
        len_next    = len_hit ? len_reg : len_reg + 1'b1;
        fail        = failed_reg || len_hit;

        if (!fail)
        begin
            if (is_digit)
            begin
                if (digits_reg == DIG_MAX)
                begin
                    fail = 1'b1;
                end
                else if ((digits_reg == DIG_ONE) && zero_reg)
                begin
                    fail = 1'b1;
                end
                else if (prod[PROD_W-1:PART_W] != '0)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    if (digits_reg == '0)
                    begin
                        zero_next = (digit_val == '0);
                    end
                    value_next  = prod[PART_W-1:0];
                    digits_next = digits_reg + 1'b1;
                end
            end
            else if (is_dot)
            begin
                if ((digits_reg == '0) || (part_reg >= LAST_PART))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    part_next   = part_reg + 1'b1;
                    digits_next = '0;
                    value_next  = '0;
                    zero_next   = 1'b0;
                end
            end
            else
            begin
                fail = 1'b1;
            end
        end

        failed_next = fail;
        ok = !fail && (part_next == LAST_PART) && (digits_next != '0);

        if (item.end_of_text)
        begin
            part_next   = FIRST_PART;
            digits_next = '0;
            value_next  = '0;
            zero_next   = 1'b0;
            len_next    = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg   <= FIRST_PART;
            digits_reg <= '0;
            value_reg  <= '0;
            zero_reg   <= 1'b0;
            len_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else if (take)
        begin
            part_reg   <= part_next;
            digits_reg <= digits_next;
            value_reg  <= value_next;
            zero_reg   <= zero_next;
            len_reg    <= len_next;
            failed_reg <= failed_next;
        end
    end

    `VSV_ASSERT_NOW(a_part_range, 1'b1, part_reg <= LAST_PART)
    `VSV_ASSERT_NOW(a_digit_range, 1'b1, digits_reg <= DIG_MAX)
    `VSV_ASSERT_NEXT(a_clear_after_end, take && item.end_of_text,
        (len_reg == '0) && !failed_reg && (part_reg == FIRST_PART) && (digits_reg == '0))

endmodule

/* rtl/vsv_out_reg.sv */
// Result register: holds the verdict until the receiver takes it.
`include "assert_macros.svh"

module vsv_out_reg
    import vsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic ok,
    output logic room,
    output logic result_valid,
    input  logic result_ready,
    output logic version_ok
);

    logic valid_reg;
    logic valid_next;
    logic ok_reg;

    assign room = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ok_reg <= ok;
        end
    end

    assign result_valid = valid_reg;
    assign version_ok   = ok_reg;

    `VSV_ASSERT_NOW(a_no_overwrite, push, room)

endmodule
